>>> design/scg_pkg.sv
// Package for the serial CRC codeword generator.
// Holds the widths, configuration defaults, register codes and the step record.
// No dependencies.
package scg_pkg;

	localparam int MAX_DEGREE = 16;
	localparam int REM_W      = MAX_DEGREE;
	localparam int CNT_W      = $clog2(MAX_DEGREE + 1);
	localparam int IDX_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

	localparam int GEN_W      = 16;
	localparam int DEG_W      = 5;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [GEN_W-1:0] GEN_RESET = GEN_W'(4129);
	localparam logic [DEG_W-1:0] DEG_RESET = DEG_W'(16);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GENERATOR = 1'b0,
		REG_DEGREE    = 1'b1
	} reg_idx_t;

	// One accepted message bit after the remainder update.
	typedef struct packed {
		logic             code_bit;
		logic             last;
		logic [REM_W-1:0] rem;
		logic [CNT_W-1:0] deg;
	} step_t;

endpackage

>>> design/scg_if.sv
// Handshake channels of the serial CRC codeword generator.
// Message-bit input channel and codeword-bit output channel; no dependencies.
interface scg_in_if;
	logic valid;
	logic ready;
	logic data_bit;
	logic last_bit;

	modport source (output valid, output data_bit, output last_bit, input ready);
	modport sink   (input valid, input data_bit, input last_bit, output ready);
endinterface

interface scg_out_if;
	logic valid;
	logic ready;
	logic code_bit;
	logic is_check;
	logic end_of_codeword;

	modport source (output valid, output code_bit, output is_check,
		output end_of_codeword, input ready);
	modport sink   (input valid, input code_bit, input is_check,
		input end_of_codeword, output ready);
endinterface

>>> design/scg_rem.sv
// Configuration registers and running CRC remainder.
// Uses scg_pkg for widths, reset values, register codes and the step record.
module scg_rem (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [scg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scg_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           fire,
	input  logic                           data_bit,
	input  logic                           last_bit,
	output scg_pkg::step_t                 step
);

	logic [scg_pkg::GEN_W-1:0] gen_q;
	logic [scg_pkg::DEG_W-1:0] deg_q;
	logic [scg_pkg::REM_W-1:0] rem_q;
	logic [scg_pkg::REM_W-1:0] rem_next;
	logic [scg_pkg::REM_W-1:0] gen_ext;
	logic [scg_pkg::CNT_W-1:0] deg_eff;
	logic [scg_pkg::IDX_W-1:0] top_idx;
	logic                      fb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= scg_pkg::GEN_RESET;
			deg_q <= scg_pkg::DEG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scg_pkg::REG_GENERATOR: gen_q <= scg_pkg::GEN_W'(cfg_data);
				scg_pkg::REG_DEGREE:    deg_q <= cfg_data[scg_pkg::DEG_W-1:0];
				default: ;
			endcase
		end
	end

	// Out-of-range degrees saturate to the legal range.
	always_comb begin
		if (deg_q == '0)
			deg_eff = scg_pkg::CNT_W'(1);
		else if (int'(deg_q) > scg_pkg::MAX_DEGREE)
			deg_eff = scg_pkg::CNT_W'(scg_pkg::MAX_DEGREE);
		else
			deg_eff = scg_pkg::CNT_W'(deg_q);
	end

	assign gen_ext = scg_pkg::REM_W'(gen_q);
	assign top_idx = scg_pkg::IDX_W'(deg_eff - scg_pkg::CNT_W'(1));
	assign fb      = data_bit ^ rem_q[top_idx];

	// One shift-and-XOR step, confined to the active degree.
	always_comb begin
		for (int i = 0; i < scg_pkg::REM_W; i++) begin
			if (i < int'(deg_eff))
				rem_next[i] = ((i > 0) ? rem_q[(i > 0) ? i - 1 : 0] : 1'b0)
					^ (fb & gen_ext[i]);
			else
				rem_next[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (fire) begin
			rem_q <= last_bit ? '0 : rem_next;
		end
	end

	assign step.code_bit = data_bit;
	assign step.last     = last_bit;
	assign step.rem      = rem_next;
	assign step.deg      = deg_eff;

endmodule

>>> design/scg_ser.sv
// Output register and check-bit serializer.
// Uses scg_pkg for the step record and widths, scg_out_if for the result channel.
module scg_ser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  scg_pkg::step_t  step,
	output logic            in_ready,
	scg_out_if.source       out_ch
);

	logic                      valid_q;
	logic                      code_q;
	logic                      chk_q;
	logic                      eoc_q;
	logic [scg_pkg::REM_W-1:0] rem_q;
	logic [scg_pkg::CNT_W-1:0] cnt_q;
	logic                      take;
	logic [scg_pkg::IDX_W-1:0] idx;

	assign take     = !valid_q || out_ch.ready;
	assign in_ready = take && (cnt_q == '0);
	assign idx      = scg_pkg::IDX_W'(cnt_q - scg_pkg::CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (fire) begin
			valid_q <= 1'b1;
			cnt_q   <= step.last ? step.deg : '0;
		end else if (take && cnt_q != '0) begin
			valid_q <= 1'b1;
			cnt_q   <= cnt_q - scg_pkg::CNT_W'(1);
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			code_q <= step.code_bit;
			chk_q  <= 1'b0;
			eoc_q  <= 1'b0;
			rem_q  <= step.rem;
		end else if (take && cnt_q != '0) begin
			code_q <= rem_q[idx];
			chk_q  <= 1'b1;
			eoc_q  <= (cnt_q == scg_pkg::CNT_W'(1));
		end
	end

	assign out_ch.valid           = valid_q;
	assign out_ch.code_bit        = code_q;
	assign out_ch.is_check        = chk_q;
	assign out_ch.end_of_codeword = eoc_q;

endmodule

>>> design/serial_crc_codeword_generator.sv
// Top level of the serial CRC codeword generator.
// Uses scg_pkg, scg_in_if, scg_out_if, scg_rem and scg_ser.
//
//   Channel   Direction  Payload                              Per item
//   in_ch     in         data_bit, last_bit                   one message bit
//   out_ch    out        code_bit, is_check, end_of_codeword  one codeword bit
//   cfg       in         cfg_we, cfg_index, cfg_data          one register write
//
// A message bit goes straight to the result register: the remainder is updated
// with one shift and XOR as the item is accepted, and the bit is presented on
// out_ch right after the accepting edge, so it can leave at the next edge.
// A bit marked last is followed by degree check bits, one per cycle while out_ch
// is not stalled, during which in_ch.ready stays low.
// Reset restores the default generator (0x1021) and degree 16 and clears the
// remainder. A stall on out_ch holds the result register and drops in_ch.ready.
module serial_crc_codeword_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	scg_in_if.sink                         in_ch,
	scg_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [scg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scg_pkg::CFG_W-1:0]      cfg_data
);

	scg_pkg::step_t step;
	logic           in_ready;
	logic           fire;

	// An item is taken when the serializer has room and no check bits remain.
	assign in_ch.ready = in_ready;
	assign fire        = in_ch.valid && in_ready;

	scg_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.data_bit  (in_ch.data_bit),
		.last_bit  (in_ch.last_bit),
		.step      (step)
	);

	scg_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.step     (step),
		.in_ready (in_ready),
		.out_ch   (out_ch)
	);

	// Every accepted message bit shows up as a non-check result next cycle.
	a_msg_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (out_ch.valid && !out_ch.is_check))
		else $error("accepted message bit not presented");

	// A check bit that is not the last one is always followed by another.
	a_chk_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.is_check && !out_ch.end_of_codeword)
		|=> (out_ch.valid && out_ch.is_check))
		else $error("check bit run broken");

	// A last message bit is followed by check bits, never by a new message bit.
	a_last_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && !out_ch.is_check && $past(fire && in_ch.last_bit))
		|=> (out_ch.valid && out_ch.is_check))
		else $error("check bits missing after last message bit");

	// The input stays closed while check bits are still being emitted.
	a_hold_in: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.is_check && !out_ch.end_of_codeword) |-> !in_ch.ready)
		else $error("input open during check bits");

endmodule

>>> dv/serial_crc_codeword_generator_tb.sv
// Self-checking testbench for the serial CRC codeword generator.
// A directed table is followed by random messages. A bit-level CRC predictor checks
// each codeword. Depends on scg_pkg, scg_in_if, scg_out_if and the design top level.
module serial_crc_codeword_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Number of random message bits, and the limit on consecutive cycles in which
	// no item moves on any channel. The longest quiet stretch is the receiver's
	// hold-off of HOLD_CYCLES, so the limit leaves a wide margin.
	localparam int RANDOM_BITS = 250;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE_CYCLES = 3;

	// One codeword bit, as the output channel carries it.
	typedef struct packed {
		logic code_bit;
		logic is_check;
		logic end_of_codeword;
	} codeword_bit_t;

	// A row of the directed table is either a message bit or a register write.
	typedef enum logic [0:0] {
		ROW_BIT,
		ROW_REG
	} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		logic                      data_bit;
		logic                      last_bit;
		logic                      typed;
		logic [scg_pkg::REM_W-1:0] check_word;
		scg_pkg::reg_idx_t         reg_index;
		logic [scg_pkg::CFG_W-1:0] reg_value;
	} stim_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we;
	logic [scg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [scg_pkg::CFG_W-1:0]     cfg_data;

	scg_in_if  in_ch ();
	scg_out_if out_ch ();

	serial_crc_codeword_generator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: its own copy of the registers and of the running remainder.
	logic [scg_pkg::GEN_W-1:0] gen_model;
	logic [scg_pkg::DEG_W-1:0] deg_model;
	logic [scg_pkg::REM_W-1:0] rem_model;

	// Codeword bits still to come from the block, oldest first.
	codeword_bit_t codeword_bits_q[$];
	stim_row_t     directed_rows[$];

	int fail_count;
	int bits_sent;
	int codewords_seen;
	int results_checked;
	int reg_writes;

	// Flags from the main sequence to the idling logic of both sides.
	bit src_calm;
	bit snk_calm;
	bit snk_hold_req;

	// A degree of zero acts as one, and anything above the maximum saturates.
	function automatic int unsigned eff_degree(logic [scg_pkg::DEG_W-1:0] d);
		if (d == '0)
			return 1;
		if (d > scg_pkg::MAX_DEGREE)
			return scg_pkg::MAX_DEGREE;
		return int'(d);
	endfunction

	// Folds one message bit into the remainder: the feedback is the message bit
	// XOR the top remainder bit, the remainder shifts left within the degree, and
	// the generator is XORed in when the feedback is set. Generator bits at or
	// above the degree fall away under the mask.
	function automatic void crc_fold_bit(logic b);
		int unsigned               d;
		logic [scg_pkg::REM_W:0]   full;
		logic [scg_pkg::REM_W-1:0] m;
		logic                      fb;
		d = eff_degree(deg_model);
		full = ({{scg_pkg::REM_W{1'b0}}, 1'b1} << d) - 1'b1;
		m = full[scg_pkg::REM_W-1:0];
		fb = b ^ rem_model[d-1];
		rem_model = (rem_model << 1) & m;
		if (fb)
			rem_model = rem_model ^ (gen_model & m);
	endfunction

	// Queues the pass-through bit and, on the last message bit, the check bits
	// msb first, with the end marker on the final one.
	function automatic void queue_codeword_bits(logic b, logic l,
		logic [scg_pkg::REM_W-1:0] chk, int unsigned d);
		codeword_bit_t cb;
		cb = '{code_bit: b, is_check: 1'b0, end_of_codeword: 1'b0};
		codeword_bits_q.push_back(cb);
		if (l) begin
			for (int unsigned k = 0; k < d; k++) begin
				cb.code_bit = chk[d-1-k];
				cb.is_check = 1'b1;
				cb.end_of_codeword = (k + 1 == d);
				codeword_bits_q.push_back(cb);
			end
		end
	endfunction

	function automatic void add_bit(logic b, logic l);
		stim_row_t r;
		r = '{kind: ROW_BIT, data_bit: b, last_bit: l, typed: 1'b0, check_word: '0,
			reg_index: scg_pkg::REG_GENERATOR, reg_value: '0};
		directed_rows.push_back(r);
	endfunction

	// A one-bit message whose check word is known by inspection.
	function automatic void add_typed(logic b, logic [scg_pkg::REM_W-1:0] chk);
		stim_row_t r;
		r = '{kind: ROW_BIT, data_bit: b, last_bit: 1'b1, typed: 1'b1, check_word: chk,
			reg_index: scg_pkg::REG_GENERATOR, reg_value: '0};
		directed_rows.push_back(r);
	endfunction

	function automatic void add_reg(scg_pkg::reg_idx_t idx, logic [scg_pkg::CFG_W-1:0] v);
		stim_row_t r;
		r = '{kind: ROW_REG, data_bit: 1'b0, last_bit: 1'b0, typed: 1'b0, check_word: '0,
			reg_index: idx, reg_value: v};
		directed_rows.push_back(r);
	endfunction

	// Offers one message bit, possibly after a random gap, and waits for the edge
	// that accepts it. The expected codeword bits are queued at that edge, either
	// from the predictor or, for typed rows, from the check word in the table.
	task automatic send_bit(logic b, logic l, logic typed, logic [scg_pkg::REM_W-1:0] chk);
		int unsigned gap;
		int unsigned d;
		gap = 0;
		while (!src_calm && $urandom_range(99) < 29)
			gap++;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_bit <= b;
		in_ch.last_bit <= l;
		do
			@(posedge clk);
		while (!(in_ch.valid && in_ch.ready));
		d = eff_degree(deg_model);
		crc_fold_bit(b);
		queue_codeword_bits(b, l, typed ? chk : rem_model, d);
		if (l)
			rem_model = '0;
		bits_sent++;
	endtask

	// Registers change only while the block is idle: the input is withdrawn,
	// every queued codeword bit must have arrived, and a settling wait follows.
	task automatic write_reg(scg_pkg::reg_idx_t idx, logic [scg_pkg::CFG_W-1:0] v);
		in_ch.valid <= 1'b0;
		while (codeword_bits_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			scg_pkg::REG_GENERATOR: begin
				gen_model = v[scg_pkg::GEN_W-1:0];
			end
			scg_pkg::REG_DEGREE: begin
				deg_model = v[scg_pkg::DEG_W-1:0];
			end
			default: begin
			end
		endcase
		reg_writes++;
	endtask

	// A degree for the random part, with the out-of-range codes and both ends of
	// the legal range drawn more often than their share. Unused upper bits of the
	// write data are random, since the block must drop them.
	function automatic logic [scg_pkg::CFG_W-1:0] pick_degree();
		logic [scg_pkg::DEG_W-1:0] d;
		case ($urandom_range(9))
			0: d = '0;
			1: d = scg_pkg::DEG_W'(1);
			2: d = scg_pkg::DEG_W'(scg_pkg::MAX_DEGREE);
			3: d = scg_pkg::DEG_W'($urandom_range(scg_pkg::MAX_DEGREE + 1, 31));
			default: d = scg_pkg::DEG_W'($urandom_range(1, scg_pkg::MAX_DEGREE));
		endcase
		return {scg_pkg::CFG_W'($urandom_range(0, 2047)) << scg_pkg::DEG_W}
			| scg_pkg::CFG_W'(d);
	endfunction

	// Main sequence: reset, directed table, random messages, drain and verdict.
	initial begin
		int unsigned msg_len;
		int          rand_count;
		logic        last;
		in_ch.valid = 1'b0;
		in_ch.data_bit = 1'b0;
		in_ch.last_bit = 1'b0;
		cfg_we = 1'b0;
		cfg_index = scg_pkg::REG_GENERATOR;
		cfg_data = '0;
		gen_model = scg_pkg::GEN_RESET;
		deg_model = scg_pkg::DEG_RESET;
		rem_model = '0;
		fail_count = 0;
		bits_sent = 0;
		codewords_seen = 0;
		results_checked = 0;
		reg_writes = 0;
		src_calm = 1'b0;
		snk_calm = 1'b0;
		snk_hold_req = 1'b0;

		// Right after reset the remainder is clear and the defaults hold, so the
		// first two one-bit messages give a zero check word and the generator.
		add_typed(1'b0, 16'h0000);
		add_typed(1'b1, 16'h1021);
		add_bit(1'b1, 1'b0);
		add_bit(1'b0, 1'b0);
		add_bit(1'b1, 1'b0);
		add_bit(1'b1, 1'b1);
		// A degree of zero acts as one, and the all-ones generator is cut to one bit.
		add_reg(scg_pkg::REG_GENERATOR, 16'hFFFF);
		add_reg(scg_pkg::REG_DEGREE, 16'd0);
		add_typed(1'b1, 16'h0001);
		// The largest degree code saturates to the full width.
		add_reg(scg_pkg::REG_DEGREE, 16'd31);
		add_typed(1'b1, 16'hFFFF);
		// An all-zero generator leaves nothing in the remainder.
		add_reg(scg_pkg::REG_GENERATOR, 16'h0000);
		add_reg(scg_pkg::REG_DEGREE, 16'd16);
		add_typed(1'b1, 16'h0000);
		// Degree just above the maximum, with a different polynomial.
		add_reg(scg_pkg::REG_GENERATOR, 16'h8005);
		add_reg(scg_pkg::REG_DEGREE, 16'd17);
		add_bit(1'b1, 1'b0);
		add_bit(1'b1, 1'b0);
		add_bit(1'b0, 1'b0);
		add_bit(1'b0, 1'b0);
		add_bit(1'b1, 1'b1);
		// The degree shrinks in the middle of a message, which then carries on.
		add_reg(scg_pkg::REG_GENERATOR, 16'h0007);
		add_reg(scg_pkg::REG_DEGREE, 16'd8);
		add_bit(1'b1, 1'b0);
		add_bit(1'b1, 1'b0);
		add_bit(1'b0, 1'b0);
		add_bit(1'b1, 1'b0);
		add_reg(scg_pkg::REG_DEGREE, 16'd5);
		add_bit(1'b0, 1'b0);
		add_bit(1'b1, 1'b1);
		// Smallest legal degree.
		add_reg(scg_pkg::REG_DEGREE, 16'd1);
		add_reg(scg_pkg::REG_GENERATOR, 16'h0001);
		add_bit(1'b1, 1'b0);
		add_bit(1'b0, 1'b1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG)
				write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
			else
				send_bit(directed_rows[i].data_bit, directed_rows[i].last_bit,
					directed_rows[i].typed, directed_rows[i].check_word);
		end

		// Random messages. Most are short, so codewords come often; a few are
		// long. Registers are sometimes rewritten between messages and, more
		// rarely, the degree changes in the middle of one.
		rand_count = 0;
		while (rand_count < RANDOM_BITS) begin
			if ($urandom_range(2) == 0)
				write_reg(scg_pkg::REG_GENERATOR,
					scg_pkg::CFG_W'($urandom_range(0, 65535)));
			if ($urandom_range(2) == 0)
				write_reg(scg_pkg::REG_DEGREE, pick_degree());
			msg_len = ($urandom_range(9) == 0) ? $urandom_range(25, 48)
				: $urandom_range(1, 16);
			for (int unsigned i = 0; i < msg_len; i++) begin
				if (i != 0 && $urandom_range(39) == 0)
					write_reg(scg_pkg::REG_DEGREE, pick_degree());
				// The receiver holds off once for a long stretch while bits keep
				// coming, and later both sides run for a while without idling.
				if (rand_count == 60)
					snk_hold_req = 1'b1;
				src_calm = (rand_count >= 150 && rand_count < 210);
				snk_calm = src_calm;
				last = (i + 1 == msg_len);
				send_bit(1'($urandom_range(1)), last, 1'b0, '0);
				rand_count++;
			end
		end

		in_ch.valid <= 1'b0;
		while (codeword_bits_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d message bits in %0d codewords, %0d codeword bits checked,",
			bits_sent, codewords_seen, results_checked);
		$display("with %0d register writes over degrees from 1 to %0d.", reg_writes,
			scg_pkg::MAX_DEGREE);
		if (fail_count == 0)
			$display("** serial_crc_codeword_generator: PASSED **");
		else
			$display("** serial_crc_codeword_generator: FAILED **");
		$finish;
	end

	// Receiver: random stalls, one long hold-off counted here, and a calm stretch.
	initial begin
		int unsigned hold_left;
		out_ch.ready = 1'b0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (snk_hold_req) begin
				snk_hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				out_ch.ready <= 1'b0;
			end else if (snk_calm) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= 29);
			end
		end
	end

	// Each accepted codeword bit is compared with the oldest expectation.
	always @(posedge clk) begin
		codeword_bit_t exp_bit;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (codeword_bits_q.size() == 0) begin
				$error("codeword bit with nothing expected: code_bit %0b is_check %0b eoc %0b",
					out_ch.code_bit, out_ch.is_check, out_ch.end_of_codeword);
				fail_count++;
			end else begin
				exp_bit = codeword_bits_q.pop_front();
				results_checked++;
				if (out_ch.code_bit !== exp_bit.code_bit) begin
					$error("code_bit: expected %0b, actual %0b", exp_bit.code_bit,
						out_ch.code_bit);
					fail_count++;
				end
				if (out_ch.is_check !== exp_bit.is_check) begin
					$error("is_check: expected %0b, actual %0b", exp_bit.is_check,
						out_ch.is_check);
					fail_count++;
				end
				if (out_ch.end_of_codeword !== exp_bit.end_of_codeword) begin
					$error("end_of_codeword: expected %0b, actual %0b",
						exp_bit.end_of_codeword, out_ch.end_of_codeword);
					fail_count++;
				end
				if (exp_bit.end_of_codeword)
					codewords_seen++;
			end
		end
	end

	// Watchdog: ends the run if nothing moves on any channel for too long.
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Timeout: no item moved for %0d cycles, %0d codeword bits outstanding.",
			STALL_LIMIT, codeword_bits_q.size());
		$display("** serial_crc_codeword_generator: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
design/scg_pkg.sv
design/scg_if.sv
design/scg_rem.sv
design/scg_ser.sv
design/serial_crc_codeword_generator.sv
dv/serial_crc_codeword_generator_tb.sv
